### design/mre_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the move-to-front / run-length encoder.
// No dependencies; every other file imports this package.
package mre_pkg;

    localparam int IDX_W  = 7;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 8;

    localparam logic [BYTE_W-1:0] RUN_FLAG = 8'h80;

    typedef enum logic
    {
        S_IDLE,
        S_SEARCH
    } mre_state_t;

    // Search unit status toward the sequencer
    typedef struct packed
    {
        logic             done;
        logic [IDX_W-1:0] idx;
    } mre_srch_stat_t;

    // Sequencer command toward the run-length packer
    typedef struct packed
    {
        logic             load;
        logic [IDX_W-1:0] idx;
        logic             last;
    } mre_rle_ctl_t;

endpackage

### design/mre_sym_if.sv
`timescale 1ns / 1ps
// Input channel of the encoder: one symbol request with its end-of-block mark.
// Depends on mre_pkg.
interface mre_sym_if
    import mre_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] symbol;
    logic             last_in;

    modport source (output valid, output symbol, output last_in, input ready);
    modport sink (input valid, input symbol, input last_in, output ready);
endinterface

### design/mre_byte_if.sv
`timescale 1ns / 1ps
// Output channel of the encoder: one coded byte request with its end-of-block mark.
// Depends on mre_pkg.
interface mre_byte_if
    import mre_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_out;

    modport source (output valid, output out_byte, output last_out, input ready);
    modport sink (input valid, input out_byte, input last_out, output ready);
endinterface

### design/mre_mtf_search.sv
`timescale 1ns / 1ps
// Move-to-front dictionary memory with its shared compare unit.
// Walks the entries one per cycle, shifting them down until the symbol is hit. Uses mre_pkg.
module mre_mtf_search
    import mre_pkg::*;
#(
    parameter int DICT_SIZE = 128
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [IDX_W-1:0] sym,
    output mre_srch_stat_t   stat
);

    localparam int AW = $clog2(DICT_SIZE);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DICT_SIZE - 1);

    logic [IDX_W-1:0] mem [DICT_SIZE];
    logic [DICT_SIZE-1:0] ent_valid_reg;

    logic             run_reg, run_next;
    logic             pipe_v_reg, pipe_v_next;
    logic [AW-1:0]    rd_addr_reg, rd_addr_next;
    logic [AW-1:0]    cmp_addr_reg;
    logic [IDX_W-1:0] rd_data_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] prev_reg, prev_next;
    logic [IDX_W-1:0] sym_reg;
    logic             done_reg, done_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic [IDX_W-1:0] cur_entry;
    logic             hit;
    logic             outside;

    // Entries never written still hold their identity value
    assign cur_entry = rd_vld_reg ? rd_data_reg : IDX_W'(cmp_addr_reg);
    assign hit       = pipe_v_reg && (cur_entry == sym_reg);
    assign outside   = {1'b0, sym} >= 8'(DICT_SIZE);

    always_comb
    begin
        run_next     = run_reg;
        pipe_v_next  = run_reg && !hit;
        rd_addr_next = rd_addr_reg;
        prev_next    = prev_reg;
        done_next    = 1'b0;
        idx_next     = idx_reg;
        if (start)
        begin
            if (outside)
            begin
                done_next = 1'b1;
                idx_next  = sym;
            end
            else
            begin
                run_next     = 1'b1;
                rd_addr_next = '0;
                prev_next    = sym;
            end
            pipe_v_next = 1'b0;
        end
        else if (run_reg)
        begin
            if (rd_addr_reg != LAST_ADDR)
            begin
                rd_addr_next = rd_addr_reg + AW'(1);
            end
            if (pipe_v_reg)
            begin
                prev_next = cur_entry;
            end
            if (hit)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
                idx_next  = IDX_W'(cmp_addr_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            pipe_v_reg    <= 1'b0;
            done_reg      <= 1'b0;
            ent_valid_reg <= '0;
        end
        else
        begin
            run_reg    <= run_next;
            pipe_v_reg <= pipe_v_next;
            done_reg   <= done_next;
            if (pipe_v_reg)
            begin
                ent_valid_reg[cmp_addr_reg] <= 1'b1;
            end
        end
    end

    // Memory port: read the next entry, write the shifted-down one
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr_reg];
        rd_vld_reg  <= ent_valid_reg[rd_addr_reg];
        if (pipe_v_reg)
        begin
            mem[cmp_addr_reg] <= prev_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_addr_reg <= rd_addr_reg;
        rd_addr_reg  <= rd_addr_next;
        prev_reg     <= prev_next;
        idx_reg      <= idx_next;
        if (start)
        begin
            sym_reg <= sym;
        end
    end

    assign stat = '{done: done_reg, idx: idx_reg};

endmodule

### design/mre_rle_pack.sv
`timescale 1ns / 1ps
// Run-length packer: holds the pending run, stages up to three coded bytes
// and drives them through an output register. Uses mre_pkg and mre_byte_if.
module mre_rle_pack
    import mre_pkg::*;
#(
    parameter int RUN_MAX = 255
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  mre_rle_ctl_t ctl,
    output logic         busy,
    mre_byte_if.source   code_ch
);

    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]  pend_cnt_reg, pend_cnt_next;

    logic [BYTE_W-1:0] q_byte_reg [3];
    logic [2:0]        q_last_reg;
    logic [1:0]        q_cnt_reg;
    logic [1:0]        q_ptr_reg;

    logic [BYTE_W-1:0] st_byte [4];
    logic [3:0]        st_last;
    logic [1:0]        st_cnt;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic              out_free;
    logic              take;

    always_comb
    begin
        logic             extend;
        logic [IDX_W-1:0] n_idx;
        logic [CNT_W-1:0] n_cnt;
        logic [1:0]       n;

        extend = (pend_cnt_reg != '0) && (ctl.idx == pend_idx_reg)
                 && (pend_cnt_reg < CNT_W'(RUN_MAX));
        n = '0;
        for (int i = 0; i < 4; i++)
        begin
            st_byte[i] = '0;
            st_last[i] = 1'b0;
        end

        // Close the old run when the new index does not extend it
        if (!extend && pend_cnt_reg != '0)
        begin
            if (pend_cnt_reg == CNT_W'(1))
            begin
                st_byte[0] = {1'b0, pend_idx_reg};
                n = 2'd1;
            end
            else
            begin
                st_byte[0] = RUN_FLAG | {1'b0, pend_idx_reg};
                st_byte[1] = pend_cnt_reg;
                n = 2'd2;
            end
        end

        if (extend)
        begin
            n_idx = pend_idx_reg;
            n_cnt = pend_cnt_reg + CNT_W'(1);
        end
        else
        begin
            n_idx = ctl.idx;
            n_cnt = CNT_W'(1);
        end

        // End of block: flush the run that is now pending
        if (ctl.last)
        begin
            if (n_cnt == CNT_W'(1))
            begin
                st_byte[n] = {1'b0, n_idx};
                st_last[n] = 1'b1;
                n = n + 2'd1;
            end
            else
            begin
                st_byte[n]        = RUN_FLAG | {1'b0, n_idx};
                st_byte[n + 2'd1] = n_cnt;
                st_last[n + 2'd1] = 1'b1;
                n = n + 2'd2;
            end
            n_cnt = '0;
        end

        st_cnt        = n;
        pend_idx_next = n_idx;
        pend_cnt_next = n_cnt;
    end

    assign busy     = (q_ptr_reg != q_cnt_reg);
    assign out_free = !out_valid_reg || code_ch.ready;
    assign take     = out_free && busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_idx_reg  <= '0;
            pend_cnt_reg  <= '0;
            q_cnt_reg     <= '0;
            q_ptr_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.load)
            begin
                pend_idx_reg <= pend_idx_next;
                pend_cnt_reg <= pend_cnt_next;
                q_cnt_reg    <= st_cnt;
                q_ptr_reg    <= '0;
            end
            else if (take)
            begin
                q_ptr_reg <= q_ptr_reg + 2'd1;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (code_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                q_byte_reg[i] <= st_byte[i];
                q_last_reg[i] <= st_last[i];
            end
        end
        if (take)
        begin
            out_byte_reg <= q_byte_reg[q_ptr_reg];
            out_last_reg <= q_last_reg[q_ptr_reg];
        end
    end

    assign code_ch.valid    = out_valid_reg;
    assign code_ch.out_byte = out_byte_reg;
    assign code_ch.last_out = out_last_reg;

endmodule

### design/mtf_rle_encoder_unit.sv
`timescale 1ns / 1ps
// Move-to-front plus run-length encoder for 7-bit symbols. One symbol request is taken
// at a time: a symbol found at dictionary position j reaches the run-length packer once
// the single compare-and-shift pass over the dictionary memory, one entry per cycle, has
// walked down to it and the search has registered its done flag; a symbol at or above
// DICT_SIZE skips the pass. The next symbol is accepted once the packer has moved
// its zero to three coded bytes into the output register, one per cycle while the sink
// takes them. The dictionary comes out of reset in identity order and is kept across blocks.
// Depends on mre_pkg, mre_sym_if, mre_byte_if, mre_mtf_search and mre_rle_pack.
module mtf_rle_encoder_unit
    import mre_pkg::*;
#(
    parameter int DICT_SIZE = 128,
    parameter int RUN_MAX   = 255
)
(
    input  logic     clk,
    input  logic     rst_n,
    mre_sym_if.sink  sym_ch,
    mre_byte_if.source code_ch
);

    mre_state_t     state_reg, state_next;
    mre_srch_stat_t srch_stat;
    mre_rle_ctl_t   rle_ctl;
    logic           rle_busy;
    logic           accept;
    logic           last_reg;

    assign accept = sym_ch.valid && sym_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (srch_stat.done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sym_ch.ready = 1'b0;
        rle_ctl.load = 1'b0;
        rle_ctl.idx  = srch_stat.idx;
        rle_ctl.last = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                sym_ch.ready = !rle_busy;
            end
            S_SEARCH:
            begin
                rle_ctl.load = srch_stat.done;
            end
            default:
            begin
                sym_ch.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the end-of-block mark while the search runs
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= sym_ch.last_in;
        end
    end

    mre_mtf_search #(
        .DICT_SIZE (DICT_SIZE)
    ) u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .sym   (sym_ch.symbol),
        .stat  (srch_stat)
    );

    mre_rle_pack #(
        .RUN_MAX (RUN_MAX)
    ) u_pack (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (rle_ctl),
        .busy    (rle_busy),
        .code_ch (code_ch)
    );

`ifndef SYNTHESIS
    a_accept_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_SEARCH)
        else $error("accepted request did not start a search");

    a_done_only_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        srch_stat.done |-> state_reg == S_SEARCH)
        else $error("search finished outside of a search");

    a_load_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        rle_ctl.load |-> !rle_busy)
        else $error("packer loaded while bytes were still staged");
`endif

endmodule

### tb/sv/mre_code_checker.sv
`timescale 1ns / 1ps
// Checker for the move-to-front / run-length encoder: watches both channels,
// predicts the coded bytes and compares them in order. Depends on mre_pkg and the channel interfaces.
module mre_code_checker
    import mre_pkg::*;
#(
    parameter int DICT_N  = 128,
    parameter int RUN_CAP = 255
)
(
    input  logic clk,
    input  logic rst_n,
    mre_sym_if   sym_mon,
    mre_byte_if  code_mon,
    output int   fail_count,
    output int   due_count,
    output int   checked_count
);

    typedef struct packed
    {
        logic [BYTE_W-1:0] value;
        logic              eob;
    } coded_byte_t;

    coded_byte_t      coded_due[$];
    logic [IDX_W-1:0] mtf_order[DICT_N];
    logic [IDX_W-1:0] run_idx;
    logic [CNT_W-1:0] run_len;

    function automatic logic [IDX_W-1:0] mtf_lookup(input logic [IDX_W-1:0] sym);
        logic [IDX_W-1:0] idx;
        begin
            // a symbol outside the table codes as itself and leaves the order alone
            idx = sym;
            for (int pos = 0; pos < DICT_N; pos++)
            begin
                if (mtf_order[pos] == sym)
                begin
                    idx = IDX_W'(pos);
                    for (int k = pos; k > 0; k--)
                        mtf_order[k] = mtf_order[k-1];
                    mtf_order[0] = sym;
                    break;
                end
            end
            return idx;
        end
    endfunction

    function automatic void flush_run(input logic eob);
        coded_byte_t cb;
        begin
            if (run_len == 1)
            begin
                cb.value = {1'b0, run_idx};
                cb.eob   = eob;
                coded_due.push_back(cb);
            end
            else if (run_len > 1)
            begin
                cb.value = RUN_FLAG | {1'b0, run_idx};
                cb.eob   = 1'b0;
                coded_due.push_back(cb);
                cb.value = run_len;
                cb.eob   = eob;
                coded_due.push_back(cb);
            end
            run_len = '0;
        end
    endfunction

    function automatic void encode_symbol(input logic [IDX_W-1:0] sym, input logic eob);
        logic [IDX_W-1:0] idx;
        begin
            idx = mtf_lookup(sym);
            if (run_len != 0 && idx == run_idx && run_len < RUN_CAP)
                run_len++;
            else
            begin
                // close the open run, split at the cap
                flush_run(1'b0);
                run_idx = idx;
                run_len = 1;
            end
            if (eob)
                flush_run(1'b1);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DICT_N; i++)
                mtf_order[i] = IDX_W'(i);
            run_idx       = '0;
            run_len       = '0;
            coded_due.delete();
            fail_count    = 0;
            due_count     = 0;
            checked_count = 0;
        end
        else
        begin
            if (code_mon.valid && code_mon.ready)
            begin
                if (coded_due.size() == 0)
                begin
                    $display("%0t: unexpected coded byte %h last %b", $time,
                             code_mon.out_byte, code_mon.last_out);
                    fail_count++;
                end
                else
                begin
                    coded_byte_t cb;
                    cb = coded_due.pop_front();
                    checked_count++;
                    if (code_mon.out_byte !== cb.value)
                    begin
                        $display("%0t: out_byte mismatch, expected %h actual %h", $time,
                                 cb.value, code_mon.out_byte);
                        fail_count++;
                    end
                    if (code_mon.last_out !== cb.eob)
                    begin
                        $display("%0t: last_out mismatch, expected %b actual %b", $time,
                                 cb.eob, code_mon.last_out);
                        fail_count++;
                    end
                end
            end
            if (sym_mon.valid && sym_mon.ready)
                encode_symbol(sym_mon.symbol, sym_mon.last_in);
            due_count = coded_due.size();
        end
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the encoder testbench: clock, reset, symbol stimulus in bursts, output stalls, verdict.
// Depends on mre_pkg, the channel interfaces, mtf_rle_encoder_unit and mre_code_checker.
module testbench;
    import mre_pkg::*;

    localparam int DICT_N      = 128;
    localparam int RUN_CAP     = 255;
    localparam int RANDOM_ITEMS = 80;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   due_count;
    int   checked_count;
    int   sent_count  = 0;
    int   block_count = 0;
    int   burst_left  = 0;
    int   rx_cycle    = 0;
    int   rx_mode     = 0;
    int   long_run    = 0;

    mre_sym_if  sym_ch ();
    mre_byte_if code_ch ();

    mtf_rle_encoder_unit #(
        .DICT_SIZE (DICT_N),
        .RUN_MAX   (RUN_CAP)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sym_ch  (sym_ch),
        .code_ch (code_ch)
    );

    mre_code_checker #(
        .DICT_N  (DICT_N),
        .RUN_CAP (RUN_CAP)
    ) code_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .sym_mon       (sym_ch),
        .code_mon      (code_ch),
        .fail_count    (fail_count),
        .due_count     (due_count),
        .checked_count (checked_count)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver: drive ready in one of four stall styles, picked anew at random
    always @(negedge clk)
    begin
        if (rx_cycle % 48 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0:       code_ch.ready <= 1'b1;
            1:       code_ch.ready <= 1'($urandom_range(0, 1));
            2:       code_ch.ready <= (rx_cycle % 4 == 0);
            default: code_ch.ready <= (rx_cycle % 16 >= 12);
        endcase
        rx_cycle++;
    end

    task automatic send_symbol(input logic [IDX_W-1:0] sym, input logic eob);
        int gap;
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 150)
                                                  : $urandom_range(0, 6);
                if (gap > 0)
                begin
                    sym_ch.valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 8);
            end
            sym_ch.valid   <= 1'b1;
            sym_ch.symbol  <= sym;
            sym_ch.last_in <= eob;
            @(posedge clk);
            while (!sym_ch.ready)
                @(posedge clk);
            @(negedge clk);
            burst_left--;
            sent_count++;
            if (eob)
                block_count++;
        end
    endtask

    initial
    begin
        logic [IDX_W-1:0] pool[4];
        logic [IDX_W-1:0] sym;
        int               len;
        int               random_sent;

        rst_n          = 1'b0;
        sym_ch.valid   = 1'b0;
        sym_ch.symbol  = '0;
        sym_ch.last_in = 1'b0;
        code_ch.ready  = 1'b0;
        random_sent    = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single-symbol block
        send_symbol(7'h00, 1'b1);
        // deepest entry, then a run of two flushed by last
        send_symbol(7'h7F, 1'b0);
        send_symbol(7'h7F, 1'b0);
        send_symbol(7'h7F, 1'b1);
        // run closed by a new index that is also last: three bytes in one request
        send_symbol(7'h55, 1'b0);
        send_symbol(7'h2A, 1'b0);
        send_symbol(7'h2A, 1'b0);
        send_symbol(7'h2A, 1'b0);
        send_symbol(7'h11, 1'b1);
        // dictionary kept across blocks
        send_symbol(7'h11, 1'b0);
        send_symbol(7'h2A, 1'b1);
        send_symbol(7'h63, 1'b0);
        send_symbol(7'h63, 1'b1);
        send_symbol(7'h40, 1'b0);
        send_symbol(7'h01, 1'b0);
        send_symbol(7'h7E, 1'b0);
        send_symbol(7'h00, 1'b1);

        while (random_sent < RANDOM_ITEMS)
        begin
            len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 24);
            for (int i = 0; i < 4; i++)
                pool[i] = IDX_W'($urandom_range(0, 127));
            sym = pool[0];
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: sym = sym;
                    4, 5, 6, 7: sym = pool[$urandom_range(0, 3)];
                    default:    sym = IDX_W'($urandom_range(0, 127));
                endcase
                send_symbol(sym, i == len - 1);
            end
            random_sent += len;

            // one long run of a single symbol, near or past the count cap
            if (long_run == 0 && random_sent > 40)
            begin
                long_run = $urandom_range(RUN_CAP, RUN_CAP + 15);
                sym      = IDX_W'($urandom_range(0, 127));
                for (int i = 0; i < long_run; i++)
                    send_symbol(sym, i == long_run - 1);
            end
        end
        sym_ch.valid <= 1'b0;

        while (due_count != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d symbols in %0d blocks, one run of %0d; %0d coded bytes checked.",
                 sent_count, block_count, long_run, checked_count);
        $display("Receiver stalled in four patterns, sender idled in random bursts.");
        if (fail_count == 0 && due_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout with %0d coded bytes outstanding.", due_count);
        $display("testbench NOT OK");
        $finish;
    end

endmodule

### mtf_rle_encoder_unit.f
design/mre_pkg.sv
design/mre_sym_if.sv
design/mre_byte_if.sv
design/mre_mtf_search.sv
design/mre_rle_pack.sv
design/mtf_rle_encoder_unit.sv
tb/sv/mre_code_checker.sv
tb/sv/testbench.sv
